/* design/ssnd_pkg.sv */
package ssnd_pkg;

   localparam int NUM_DIGITS    = 6;
   localparam int MAX_HEX_BYTES = 3;

   localparam int VALUE_W     = 20;
   localparam int HEX_W       = 24;
   localparam int BYTE_CNT_W  = 8;
   localparam int SELECT_W    = 8;
   localparam int SEG_W       = 7;
   localparam int POSITION_W  = 3;

   localparam int DIG_W       = 4 * NUM_DIGITS;
   localparam int POS_W       = $clog2(NUM_DIGITS);
   localparam int CNT_W       = $clog2(NUM_DIGITS + 1);
   localparam int BIT_CNT_W   = $clog2(VALUE_W);
   localparam int HEX_LIMIT   = (MAX_HEX_BYTES < NUM_DIGITS / 2) ?
                                MAX_HEX_BYTES : NUM_DIGITS / 2;

   function automatic logic [31:0] pow10(input int n);
      logic [31:0] acc;
      acc = 32'd1;
      for (int i = 0; i < n; i++) begin
         acc = acc * 32'd10;
      end
      return acc;
   endfunction

   localparam logic [31:0] DEC_LIMIT = pow10(NUM_DIGITS) - 32'd1;

   localparam logic [SEG_W-1:0] SEG_TABLE [16] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
      7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71
   };

   function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] nibble);
      return SEG_TABLE[nibble];
   endfunction

   typedef enum logic {
      OP_DECIMAL = 1'b0,
      OP_HEX     = 1'b1
   } ssnd_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_FINISH,
      ST_EMIT
   } ssnd_state_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic finish;
      logic emit;
   } ssnd_cmd_type;

   typedef struct packed {
      logic conv_done;
      logic last;
   } ssnd_status_type;

endpackage

/* design/ssnd_ctrl.sv */
module ssnd_ctrl
   import ssnd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic            req_operation,
   input  ssnd_status_type status,
   output ssnd_cmd_type    cmd,
   output logic            busy,
   output logic            rsp_valid
);

   ssnd_state_type state_ff;
   ssnd_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = (req_operation == OP_HEX) ? ST_EMIT : ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.shift = 1'b1;
            if (status.conv_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);

endmodule

/* design/ssnd_datapath.sv */
module ssnd_datapath
   import ssnd_pkg::*;
(
   input  logic                  clock,
   input  ssnd_cmd_type          cmd,
   input  logic                  req_operation,
   input  logic [VALUE_W-1:0]    req_value,
   input  logic [HEX_W-1:0]      req_hex_bytes,
   input  logic [BYTE_CNT_W-1:0] req_byte_count,
   output ssnd_status_type       status,
   output logic [SELECT_W-1:0]   rsp_digit_select,
   output logic [SEG_W-1:0]      rsp_segments,
   output logic [POSITION_W-1:0] rsp_digit_position,
   output logic                  rsp_last
);

   logic [VALUE_W-1:0]   bin_ff,     bin_in;
   logic [DIG_W-1:0]     digits_ff,  digits_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [CNT_W-1:0]     count_ff,   count_in;
   logic [POS_W-1:0]     pos_ff,     pos_in;

   logic [VALUE_W-1:0]     sat_value;
   logic [DIG_W-1:0]       adjusted;
   logic [DIG_W-1:0]       hex_ext;
   logic [CNT_W-1:0]       hex_count;
   logic [CNT_W-1:0]       dec_count;
   logic [3:0]             nib;

   always_comb begin
      if ({{(32 - VALUE_W){1'b0}}, req_value} > DEC_LIMIT) begin
         sat_value = DEC_LIMIT[VALUE_W-1:0];
      end else begin
         sat_value = req_value;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         nib = digits_ff[4*i +: 4];
         adjusted[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
      end
   end

   assign hex_ext = DIG_W'(req_hex_bytes);

   always_comb begin
      priority if (req_byte_count == '0) begin
         hex_count = CNT_W'(1);
      end else if (req_byte_count >= BYTE_CNT_W'(HEX_LIMIT)) begin
         hex_count = CNT_W'(2 * HEX_LIMIT);
      end else begin
         hex_count = CNT_W'(2 * req_byte_count);
      end
   end

   always_comb begin
      dec_count = CNT_W'(1);
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (digits_ff[4*i +: 4] != 4'd0) begin
            dec_count = CNT_W'(i + 1);
         end
      end
   end

   always_comb begin
      bin_in     = bin_ff;
      digits_in  = digits_ff;
      bit_cnt_in = bit_cnt_ff;
      count_in   = count_ff;
      pos_in     = pos_ff;
      if (cmd.load) begin
         pos_in     = '0;
         bit_cnt_in = '0;
         if (req_operation == OP_HEX) begin
            digits_in = (req_byte_count == '0) ? '0 : hex_ext;
            count_in  = hex_count;
         end else begin
            digits_in = '0;
            bin_in    = sat_value;
         end
      end
      if (cmd.shift) begin
         digits_in  = {adjusted[DIG_W-2:0], bin_ff[VALUE_W-1]};
         bin_in     = {bin_ff[VALUE_W-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
      end
      if (cmd.finish) begin
         count_in = dec_count;
      end
      if (cmd.emit) begin
         digits_in = {4'd0, digits_ff[DIG_W-1:4]};
         pos_in    = pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      bin_ff     <= bin_in;
      digits_ff  <= digits_in;
      bit_cnt_ff <= bit_cnt_in;
      count_ff   <= count_in;
      pos_ff     <= pos_in;
   end

   assign status.conv_done = (bit_cnt_ff == BIT_CNT_W'(VALUE_W - 1));
   assign status.last      = (CNT_W'(pos_ff) + CNT_W'(1) == count_ff);

   assign rsp_last           = status.last;
   assign rsp_segments       = seg_of(digits_ff[3:0]);
   assign rsp_digit_position = POSITION_W'(pos_ff);
   assign rsp_digit_select   =
      ~(SELECT_W'(1) << (POSITION_W'(NUM_DIGITS - 1) - POSITION_W'(pos_ff)));

endmodule

/* design/seven_segment_number_display.sv */
// Six-digit seven-segment display driver. A request is taken at the rising
// clock edge where start is high and busy is low; its fields are req_operation
// (0 decimal, 1 hex), req_value, req_hex_bytes and req_byte_count. The block
// then answers with one transaction per shown digit, units digit first, each
// marked by rsp_valid for exactly one cycle, with rsp_last on the final one.
// Decimal requests saturate at 999999, are converted by a shift-and-add-three
// loop that handles one bit of the 20-bit value per cycle, and blank leading
// zeros. Hex requests show two nibbles per byte for up to three bytes.
// A decimal request passes through the conversion state, then a finish state
// that finds the digit count, and then emits its N digits (1 to 6). A hex
// request goes straight to emitting, showing its first digit in the cycle
// after acceptance, and shows 2 * bytes digits (one digit for a count of
// zero). busy is high from the cycle after acceptance through the last digit;
// one request is handled at a time, and the next one can be accepted in the
// cycle after the last digit.
// Reset returns the controller to idle and drops any request in progress.
// The receiver cannot stall; every digit is taken in the cycle it is shown.
module seven_segment_number_display
   import ssnd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_operation,
   input  logic [VALUE_W-1:0]    req_value,
   input  logic [HEX_W-1:0]      req_hex_bytes,
   input  logic [BYTE_CNT_W-1:0] req_byte_count,
   output logic                  rsp_valid,
   output logic [SELECT_W-1:0]   rsp_digit_select,
   output logic [SEG_W-1:0]      rsp_segments,
   output logic [POSITION_W-1:0] rsp_digit_position,
   output logic                  rsp_last
);

   ssnd_cmd_type    cmd;
   ssnd_status_type status;

   ssnd_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd),
      .busy          (busy),
      .rsp_valid     (rsp_valid)
   );

   ssnd_datapath u_datapath (
      .clock              (clock),
      .cmd                (cmd),
      .req_operation      (req_operation),
      .req_value          (req_value),
      .req_hex_bytes      (req_hex_bytes),
      .req_byte_count     (req_byte_count),
      .status             (status),
      .rsp_digit_select   (rsp_digit_select),
      .rsp_segments       (rsp_segments),
      .rsp_digit_position (rsp_digit_position),
      .rsp_last           (rsp_last)
   );

endmodule

/* design/ssnd_checker.sv */
module ssnd_checker
   import ssnd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input logic [POSITION_W-1:0] rsp_digit_position,
   input logic                  rsp_last
);

   a_valid_only_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("A digit transaction appeared while the block was idle.");

   a_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("An accepted request did not make the block busy.");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !rsp_valid)
      else $error("A digit transaction followed the last one of a request.");

   a_position_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=>
         (rsp_valid && rsp_digit_position ==
            POSITION_W'($past(rsp_digit_position) + POSITION_W'(1))))
      else $error("Digit positions did not advance by one within a request.");

endmodule

bind seven_segment_number_display ssnd_checker u_ssnd_checker (.*);
